// ----- rtl/bgmc_pkg.sv -----
`timescale 1ns / 1ps

package bgmc_pkg;

    // field widths
    localparam int unsigned PixW    = 8;
    localparam int unsigned AddrW   = 19;
    localparam int unsigned CntW    = 8;
    localparam int unsigned WarmW   = 4;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgW    = 8;

    // one store entry per raster position, addressed by the full address field
    localparam int unsigned FramePixels = 1 << AddrW;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_DIFF_THRESHOLD   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_UPDATE_LIMIT     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_WARMUP_FRAMES    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_WARMUP_INCREMENT = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_STEADY_INCREMENT = 3'd4;

    // register reset values
    localparam logic [PixW-1:0]  RST_DIFF_THRESHOLD   = 8'd20;
    localparam logic [CntW-1:0]  RST_UPDATE_LIMIT     = 8'd70;
    localparam logic [WarmW-1:0] RST_WARMUP_FRAMES    = 4'd10;
    localparam logic [CntW-1:0]  RST_WARMUP_INCREMENT = 8'd15;
    localparam logic [CntW-1:0]  RST_STEADY_INCREMENT = 8'd2;

    localparam logic [CntW-1:0] CNT_MAX = 8'd255;

    // one store entry: background level and conflict count
    typedef struct packed {
        logic [PixW-1:0] bg;
        logic [CntW-1:0] cnt;
    } t_entry;

    // pixel context handed to the update logic
    typedef struct packed {
        logic [PixW-1:0] pix;
        logic            first;
        logic            warm;
    } t_pix_ctx;

    // live configuration
    typedef struct packed {
        logic [PixW-1:0] thr;
        logic [CntW-1:0] limit;
        logic [CntW-1:0] warm_inc;
        logic [CntW-1:0] steady_inc;
    } t_cfg;

    // update result
    typedef struct packed {
        t_entry entry;
        logic   fg;
        logic   replaced;
    } t_upd;

endpackage

// ----- rtl/bgmc_update.sv -----
`timescale 1ns / 1ps

module bgmc_update
    import bgmc_pkg::*;
(
    input  t_pix_ctx i_ctx,
    input  t_entry   i_entry,
    input  t_cfg     i_cfg,
    output t_upd     o_upd
);

    logic [PixW-1:0] bg;
    logic [CntW-1:0] cnt0;
    logic [PixW-1:0] diff;
    logic            fg;
    logic [CntW:0]   sum1;
    logic [CntW-1:0] cnt1;
    logic [CntW:0]   sum2;
    logic [CntW-1:0] cnt2;

    // first frame loads the pixel and a cleared counter
    assign bg   = i_ctx.first ? i_ctx.pix : i_entry.bg;
    assign cnt0 = i_ctx.first ? '0 : i_entry.cnt;

    // absolute difference and threshold compare
    assign diff = (i_ctx.pix >= bg) ? (i_ctx.pix - bg) : (bg - i_ctx.pix);
    assign fg   = (diff >= i_cfg.thr);

    // warm-up add then steady add, each saturating
    assign sum1 = {1'b0, cnt0} + ((fg && i_ctx.warm) ? {1'b0, i_cfg.warm_inc} : '0);
    assign cnt1 = sum1[CntW] ? CNT_MAX : sum1[CntW-1:0];
    assign sum2 = {1'b0, cnt1} + (fg ? {1'b0, i_cfg.steady_inc} : '0);
    assign cnt2 = sum2[CntW] ? CNT_MAX : sum2[CntW-1:0];

    // replace above the limit, otherwise decay toward zero
    always_comb begin
        o_upd.fg        = fg;
        o_upd.replaced  = 1'b0;
        o_upd.entry.bg  = bg;
        o_upd.entry.cnt = cnt2;
        if (cnt2 > i_cfg.limit) begin
            o_upd.entry.bg  = i_ctx.pix;
            o_upd.entry.cnt = '0;
            o_upd.replaced  = 1'b1;
        end else if (cnt2 != '0) begin
            o_upd.entry.cnt = cnt2 - 1'b1;
        end
    end

endmodule

// ----- rtl/background_model_conflict_update.sv -----
`timescale 1ns / 1ps

// channel   | dir | signals                         | content
// ----------+-----+---------------------------------+------------------------------------
// s (pixel) | in  | i_s_tvalid o_s_tready i_s_tdata | tdata: gray_level[7:0],
//           |     | i_s_tlast                       |   pixel_addr[26:8]; tlast: end_of_frame
// m (pixel) | out | o_m_tvalid i_m_tready o_m_tdata | tdata: foreground[0],
//           |     |                                 |   background_level[8:1], replaced[9]
// cfg       | in  | i_cfg_we i_cfg_idx i_cfg_data   | register write, no read-back
//
// one pixel per clock sustained while results are taken; a request's registered
// read of the entry store feeds one update stage, which loads the result register.
// a pixel at the address of the one just before it takes the written-back
// entry through a forwarding register. synchronous active-low reset clears
// control and loads register defaults; the store needs no clearing since the
// first frame writes every entry. a stalled result holds the update stage.

module background_model_conflict_update
    import bgmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // pixel request in
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [31:0]        i_s_tdata,   // gray_level[7:0], pixel_addr[26:8]
    input  logic               i_s_tlast,   // end_of_frame
    // pixel result out
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [15:0]        o_m_tdata,   // foreground[0], background_level[8:1], replaced[9]
    // configuration
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data
);

    // configuration registers
    t_cfg             r_cfg;
    logic             r_first;
    logic [WarmW-1:0] r_warm_left;

    // entry store
    t_entry           r_mem [FramePixels];
    t_entry           r_rd_data;

    // update stage
    logic             r_s1_valid;
    logic [AddrW-1:0] r_s1_addr;
    t_pix_ctx         r_s1_ctx;
    logic             r_fwd_hit;
    t_entry           r_fwd_data;

    // result register
    logic             r_out_valid;
    logic [15:0]      r_out_data;

    logic             s_acc;
    logic             s1_adv;
    logic [PixW-1:0]  in_pix;
    logic [AddrW-1:0] in_addr;
    t_entry           s1_entry;
    t_upd             upd;

    assign in_pix  = i_s_tdata[PixW-1:0];
    assign in_addr = i_s_tdata[PixW+AddrW-1:PixW];

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = i_rst_n && (!r_s1_valid || s1_adv);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // configuration writes and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr        <= RST_DIFF_THRESHOLD;
            r_cfg.limit      <= RST_UPDATE_LIMIT;
            r_cfg.warm_inc   <= RST_WARMUP_INCREMENT;
            r_cfg.steady_inc <= RST_STEADY_INCREMENT;
            r_first          <= 1'b1;
            r_warm_left      <= RST_WARMUP_FRAMES;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DIFF_THRESHOLD:   r_cfg.thr        <= i_cfg_data;
                    CFG_UPDATE_LIMIT:     r_cfg.limit      <= i_cfg_data;
                    CFG_WARMUP_FRAMES: begin
                        if (r_first) begin
                            r_warm_left <= i_cfg_data[WarmW-1:0];
                        end
                    end
                    CFG_WARMUP_INCREMENT: r_cfg.warm_inc   <= i_cfg_data;
                    CFG_STEADY_INCREMENT: r_cfg.steady_inc <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_acc && i_s_tlast) begin
                r_first <= 1'b0;
                if (r_warm_left != '0) begin
                    r_warm_left <= r_warm_left - 1'b1;
                end
            end
        end
    end

    // store read on request, write back as the update stage retires
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_rd_data <= r_mem[in_addr];
        end
        if (s1_adv) begin
            r_mem[r_s1_addr] <= upd.entry;
        end
    end

    // update stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (s_acc) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= s1_adv && (r_s1_addr == in_addr);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // update stage payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_addr      <= in_addr;
            r_s1_ctx.pix   <= in_pix;
            r_s1_ctx.first <= r_first;
            r_s1_ctx.warm  <= (r_warm_left != '0);
            r_fwd_data     <= upd.entry;
        end
    end

    // forwarded entry covers a write landing on the same edge as the read
    assign s1_entry = r_fwd_hit ? r_fwd_data : r_rd_data;

    bgmc_update u_update (
        .i_ctx   (r_s1_ctx),
        .i_entry (s1_entry),
        .i_cfg   (r_cfg),
        .o_upd   (upd)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {6'd0, upd.replaced, upd.entry.bg, upd.fg};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
